/* rtl/preferential_attachment_graph_gen_macros.svh */
// ---------------------------------------------------------------------------
// Preferential attachment generator assertion macros
// Clocked assertion helpers used by the generator RTL, which checks itself.
// ---------------------------------------------------------------------------
`ifndef PREFERENTIAL_ATTACHMENT_GRAPH_GEN_MACROS_SVH
`define PREFERENTIAL_ATTACHMENT_GRAPH_GEN_MACROS_SVH

// property checked every edge outside reset
`define PAGG_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent / consequent form
`define PAGG_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/pagg_pkg.sv */
// ---------------------------------------------------------------------------
// Preferential attachment generator package
// Word types, field widths, codes and fixed-point constants.
// ---------------------------------------------------------------------------
package pagg_pkg;

    localparam int VTX_W      = 10;
    localparam int DRAW_W     = 16;
    localparam int WEIGHT_W   = 15;
    localparam int DEG_W      = 10;
    localparam int EDGE_W     = 14;
    localparam int REM_W      = 17;
    localparam int VCNT_W     = 11;
    localparam int SCNT_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int PROD_W     = DRAW_W + WEIGHT_W;

    localparam logic [DEG_W-1:0]  DEG_MAX   = 10'd1023;
    localparam logic [EDGE_W-1:0] EDGE_MAX  = 14'd16383;
    localparam logic [16:0]       FRAC_MAX  = 17'd65535;
    localparam logic [31:0]       FRAC_HALF = 32'd32767;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_DRAW  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_COUNT   = 2'd1;

    typedef struct packed {
        logic              mode;
        logic [DRAW_W-1:0] draw;
    } req_t;

    typedef struct packed {
        logic [VTX_W-1:0] src_vertex;
        logic [VTX_W-1:0] dst_vertex;
        logic             edge_valid;
        logic             last;
        logic             done_res;
    } rsp_t;

    typedef struct packed {
        logic                go;
        logic [DRAW_W-1:0]   draw;
        logic [WEIGHT_W-1:0] weight;
    } scale_req_t;

    typedef struct packed {
        logic                done;
        logic [WEIGHT_W-1:0] value;
    } scale_rsp_t;

endpackage

/* rtl/pagg_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module pagg_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/pagg_scale.sv */
// ---------------------------------------------------------------------------
// Draw scaler
// value = round(draw * weight / 65535), half up; two-stage pipeline.
// ---------------------------------------------------------------------------
module pagg_scale (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pagg_pkg::scale_req_t   req,
    output pagg_pkg::scale_rsp_t   rsp
);

    localparam int PW  = pagg_pkg::PROD_W;
    localparam int DW  = pagg_pkg::DRAW_W;
    localparam int WTW = pagg_pkg::WEIGHT_W;

    logic          s1_vld_reg, s1_vld_next;
    logic          s2_vld_reg, s2_vld_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [WTW-1:0] val_reg, val_next;

    logic [31:0] sum;
    logic [15:0] q0;
    logic [16:0] rmd;
    logic [15:0] q;

    // x / 65535 = (x >> 16) + correction, remainder (x & 0xffff) + (x >> 16)
    always_comb
    begin
        s1_vld_next = req.go;
        s2_vld_next = s1_vld_reg;
        prod_next   = PW'(req.draw) * PW'(req.weight);
        sum         = 32'(prod_reg) + pagg_pkg::FRAC_HALF;
        q0          = sum[31:16];
        rmd         = {1'b0, sum[15:0]} + {1'b0, q0};
        q           = q0 + ((rmd >= pagg_pkg::FRAC_MAX) ? 16'd1 : 16'd0);
        val_next    = q[WTW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        val_reg  <= val_next;
    end

    assign rsp.done  = s2_vld_reg;
    assign rsp.value = val_reg;

endmodule

/* rtl/preferential_attachment_graph_gen.sv */
// ---------------------------------------------------------------------------
// Preferential attachment graph generator
// Request words carry a mode bit and a 16-bit draw; response words carry one
// edge (src, dst) with edge_valid, last and done flags. The config port
// writes vertex_count (index 0) and seed_count (index 1); it is always ready
// and its values are sampled when a start word is taken.
// A start word sweeps the degree RAM, one entry per cycle, then emits the
// seed clique at one edge per cycle while the output is free, last on the
// final edge, or one last word with no edge for an empty clique. A draw
// word passes through the scaler, then walks the degree RAM one vertex per
// cycle over the vertices below new_vertex through the single RAM read port,
// then updates the chosen vertex and the new vertex. One draw gives exactly
// one response word. One word is in work at a time; a new request is taken
// while the last response still waits in the output register. A stalled
// response holds and the block waits for it before loading the next one.
// Reset: no run is active, draws report done until the first start.
// ---------------------------------------------------------------------------
`include "preferential_attachment_graph_gen_macros.svh"

module preferential_attachment_graph_gen #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_SEEDS    = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  pagg_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output pagg_pkg::rsp_t                      rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pagg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pagg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int NW   = AW + 1;
    localparam int SW   = $clog2(MAX_SEEDS + 1);
    localparam int SIW  = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam int VW   = pagg_pkg::VTX_W;
    localparam int DGW  = pagg_pkg::DEG_W;
    localparam int ETW  = pagg_pkg::EDGE_W;
    localparam int WTW  = pagg_pkg::WEIGHT_W;
    localparam int RMW  = pagg_pkg::REM_W;
    localparam int VCW  = pagg_pkg::VCNT_W;
    localparam int SCW  = pagg_pkg::SCNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CLIQUE,
        ST_SCALE,
        ST_WALK,
        ST_SRC,
        ST_RES
    } state_t;

    state_t                state_reg, state_next;
    logic [VCW-1:0]        vcnt_reg, vcnt_next;
    logic [SCW-1:0]        scnt_reg, scnt_next;
    logic [NW-1:0]         rv_reg, rv_next;
    logic [SW-1:0]         rs_reg, rs_next;
    logic [NW-1:0]         nv_reg, nv_next;
    logic [SW-1:0]         cc_reg, cc_next;
    logic [ETW-1:0]        et_reg, et_next;
    logic [WTW-1:0]        wt_reg, wt_next;
    logic                  fin_reg, fin_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [SW-1:0]         ci_reg, ci_next;
    logic [SW-1:0]         cj_reg, cj_next;
    logic [NW-1:0]         ja_reg, ja_next;
    logic                  dv_reg, dv_next;
    logic [AW-1:0]         jd_reg, jd_next;
    logic                  tk_reg, tk_next;
    logic signed [RMW-1:0] rem_reg, rem_next;
    logic [AW-1:0]         dst_reg, dst_next;
    pagg_pkg::rsp_t        res_reg, res_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    pagg_pkg::rsp_t        rsp_reg, rsp_next;

    logic [AW-1:0]         chosen_reg [MAX_SEEDS];
    logic                  chosen_we;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DGW-1:0]        ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DGW-1:0]        ram_rdata;

    pagg_pkg::scale_req_t  scl_req;
    pagg_pkg::scale_rsp_t  scl_rsp;

    logic [31:0]           vc_ext, sc_ext, nvc, nsc;
    logic                  out_free;
    logic                  out_load;
    pagg_pkg::rsp_t        out_word;
    logic                  taken;
    logic signed [RMW-1:0] rem_sub;
    logic                  hit;
    logic                  clq_last;
    logic [ETW-1:0]        et_inc;
    logic [NW-1:0]         nv_inc;

    pagg_ram #(
        .WIDTH (DGW),
        .DEPTH (MAX_VERTICES)
    ) u_degree_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pagg_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scl_req),
        .rsp   (scl_rsp)
    );

    // run sizes as a start word would latch them
    always_comb
    begin
        vc_ext = 32'(vcnt_reg);
        sc_ext = 32'(scnt_reg);
        if (vc_ext == 32'd0)
        begin
            nvc = 32'd1;
        end
        else if (vc_ext > 32'(MAX_VERTICES))
        begin
            nvc = 32'(MAX_VERTICES);
        end
        else
        begin
            nvc = vc_ext;
        end
        if (sc_ext == 32'd0)
        begin
            nsc = 32'd1;
        end
        else if (sc_ext > 32'(MAX_SEEDS))
        begin
            nsc = 32'(MAX_SEEDS);
        end
        else
        begin
            nsc = sc_ext;
        end
        if (nsc > nvc)
        begin
            nsc = nvc;
        end
    end

    // skip vertices already picked by the current new vertex
    always_comb
    begin
        taken = 1'b0;
        for (int d = 0; d < MAX_SEEDS; d++)
        begin
            if ((SW'(d) < cc_reg) && (chosen_reg[d] == ja_reg[AW-1:0]))
            begin
                taken = 1'b1;
            end
        end
    end

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rem_sub   = rem_reg - RMW'(ram_rdata);
    assign hit       = dv_reg && !tk_reg && (rem_sub[RMW-1] || (rem_sub == '0));
    assign clq_last  = (cj_reg == rs_reg - SW'(1)) && (ci_reg + SW'(2) == rs_reg);
    assign et_inc    = (et_reg == pagg_pkg::EDGE_MAX) ? et_reg : et_reg + ETW'(1);
    assign nv_inc    = nv_reg + NW'(1);

    always_comb
    begin
        state_next     = state_reg;
        vcnt_next      = vcnt_reg;
        scnt_next      = scnt_reg;
        rv_next        = rv_reg;
        rs_next        = rs_reg;
        nv_next        = nv_reg;
        cc_next        = cc_reg;
        et_next        = et_reg;
        wt_next        = wt_reg;
        fin_next       = fin_reg;
        clr_next       = clr_reg;
        ci_next        = ci_reg;
        cj_next        = cj_reg;
        ja_next        = ja_reg;
        dv_next        = dv_reg;
        jd_next        = jd_reg;
        tk_next        = tk_reg;
        rem_next       = rem_reg;
        dst_next       = dst_reg;
        res_next       = res_reg;
        chosen_we      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = clr_reg;
        ram_wdata      = '0;
        ram_raddr      = ja_reg[AW-1:0];
        scl_req.go     = 1'b0;
        scl_req.draw   = req.draw;
        scl_req.weight = wt_reg;
        out_load       = 1'b0;
        out_word       = '0;

        if (cfg_valid)
        begin
            case (cfg_index)
                pagg_pkg::REG_VERTEX_COUNT: vcnt_next = cfg_data[VCW-1:0];
                pagg_pkg::REG_SEED_COUNT:   scnt_next = cfg_data[SCW-1:0];
                default:                    ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.mode == pagg_pkg::MODE_START)
                    begin
                        rv_next    = NW'(nvc);
                        rs_next    = SW'(nsc);
                        nv_next    = NW'(nsc);
                        cc_next    = '0;
                        et_next    = '0;
                        wt_next    = '0;
                        fin_next   = (nsc >= nvc);
                        clr_next   = '0;
                        ci_next    = '0;
                        cj_next    = SW'(1);
                        state_next = ST_CLEAR;
                    end
                    else if (fin_reg || (nv_reg >= NW'(MAX_VERTICES))
                             || (cc_reg >= SW'(MAX_SEEDS)))
                    begin
                        res_next.src_vertex = '0;
                        res_next.dst_vertex = '0;
                        res_next.edge_valid = 1'b0;
                        res_next.last       = 1'b1;
                        res_next.done_res   = 1'b1;
                        state_next          = ST_RES;
                    end
                    else
                    begin
                        scl_req.go = 1'b1;
                        state_next = ST_SCALE;
                    end
                end
            end

            // seed vertices start at degree seed_count - 1, all others at zero
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = (clr_reg < rs_reg) ? DGW'(rs_reg - SW'(1)) : '0;
                if (clr_reg == AW'(MAX_VERTICES - 1))
                begin
                    state_next = ST_CLIQUE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            ST_CLIQUE:
            begin
                if (out_free)
                begin
                    out_load          = 1'b1;
                    out_word.done_res = fin_reg;
                    if (rs_reg == SW'(1))
                    begin
                        out_word.last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        out_word.src_vertex = VW'(ci_reg);
                        out_word.dst_vertex = VW'(cj_reg);
                        out_word.edge_valid = 1'b1;
                        out_word.last       = clq_last;
                        et_next             = et_inc;
                        wt_next             = {et_inc, 1'b0};
                        if (clq_last)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (cj_reg == rs_reg - SW'(1))
                        begin
                            ci_next = ci_reg + SW'(1);
                            cj_next = ci_reg + SW'(2);
                        end
                        else
                        begin
                            cj_next = cj_reg + SW'(1);
                        end
                    end
                end
            end

            ST_SCALE:
            begin
                if (scl_rsp.done)
                begin
                    rem_next   = RMW'(scl_rsp.value);
                    ja_next    = '0;
                    dv_next    = 1'b0;
                    state_next = ST_WALK;
                end
            end

            // read issued the cycle before the subtract; no write overlaps a read
            ST_WALK:
            begin
                if (dv_reg && !tk_reg && !hit)
                begin
                    rem_next = rem_sub;
                end
                if (hit)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = jd_reg;
                    ram_wdata  = (ram_rdata == pagg_pkg::DEG_MAX) ?
                                 ram_rdata : ram_rdata + DGW'(1);
                    wt_next    = (wt_reg >= WTW'(ram_rdata)) ?
                                 wt_reg - WTW'(ram_rdata) : '0;
                    chosen_we  = 1'b1;
                    cc_next    = cc_reg + SW'(1);
                    et_next    = et_inc;
                    dst_next   = jd_reg;
                    dv_next    = 1'b0;
                    state_next = ST_SRC;
                end
                else if (ja_reg < nv_reg)
                begin
                    dv_next = 1'b1;
                    jd_next = ja_reg[AW-1:0];
                    tk_next = taken;
                    ja_next = ja_reg + NW'(1);
                end
                else if (dv_reg)
                begin
                    dv_next = 1'b0;
                end
                else
                begin
                    res_next.src_vertex = '0;
                    res_next.dst_vertex = '0;
                    res_next.edge_valid = 1'b0;
                    res_next.last       = 1'b1;
                    res_next.done_res   = 1'b0;
                    state_next          = ST_RES;
                end
            end

            // degree of the new vertex equals its choices so far
            ST_SRC:
            begin
                ram_we              = 1'b1;
                ram_waddr           = nv_reg[AW-1:0];
                ram_wdata           = DGW'(cc_reg);
                res_next.src_vertex = VW'(nv_reg);
                res_next.dst_vertex = VW'(dst_reg);
                res_next.edge_valid = 1'b1;
                res_next.last       = 1'b1;
                res_next.done_res   = fin_reg;
                if (cc_reg >= rs_reg)
                begin
                    cc_next = '0;
                    nv_next = nv_inc;
                    wt_next = {et_reg, 1'b0};
                    if (nv_inc >= rv_reg)
                    begin
                        fin_next          = 1'b1;
                        res_next.done_res = 1'b1;
                    end
                end
                state_next = ST_RES;
            end

            ST_RES:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_word   = res_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = out_word;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
            rsp_next       = rsp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vcnt_reg      <= VCW'(1024);
            scnt_reg      <= SCW'(4);
            rv_reg        <= NW'(1);
            rs_reg        <= SW'(1);
            nv_reg        <= '0;
            cc_reg        <= '0;
            et_reg        <= '0;
            wt_reg        <= '0;
            fin_reg       <= 1'b1;
            clr_reg       <= '0;
            ci_reg        <= '0;
            cj_reg        <= '0;
            ja_reg        <= '0;
            dv_reg        <= 1'b0;
            tk_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            vcnt_reg      <= vcnt_next;
            scnt_reg      <= scnt_next;
            rv_reg        <= rv_next;
            rs_reg        <= rs_next;
            nv_reg        <= nv_next;
            cc_reg        <= cc_next;
            et_reg        <= et_next;
            wt_reg        <= wt_next;
            fin_reg       <= fin_next;
            clr_reg       <= clr_next;
            ci_reg        <= ci_next;
            cj_reg        <= cj_next;
            ja_reg        <= ja_next;
            dv_reg        <= dv_next;
            tk_reg        <= tk_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        jd_reg  <= jd_next;
        rem_reg <= rem_next;
        dst_reg <= dst_next;
        res_reg <= res_next;
        if (chosen_we)
        begin
            chosen_reg[cc_reg[SIW-1:0]] <= jd_reg;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    `PAGG_ASSERT_IMPL(a_walk_in_range, (state_reg == ST_WALK) && dv_reg, NW'(jd_reg) < nv_reg, "walk read beyond the new vertex")
    `PAGG_ASSERT(a_weight_bound, wt_reg <= {et_reg, 1'b0}, "open weight above twice the edge total")
    `PAGG_ASSERT_IMPL(a_scale_latency, scl_req.go, ##2 scl_rsp.done, "scaler result not back after two cycles")
    `PAGG_ASSERT_IMPL(a_choice_bound, (state_reg == ST_IDLE) && !fin_reg, cc_reg < rs_reg, "choice count reached the seed count while idle")

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Preferential attachment generator testbench
// Drives start and draw words into the generator, keeps its own copy of the
// degree store and run state to predict every edge word, and checks each
// response word in order. Directed runs cover the register limits, the empty
// clique, draws before a start and after the last vertex, the extreme draw
// values and a long receiver hold-off. Random runs follow under four idling patterns.
// ---------------------------------------------------------------------------
module tb_top;
    import pagg_pkg::*;

    localparam int MAX_V        = 1024;
    localparam int MAX_S        = 8;
    localparam int WEIGHT_CAP   = 2**WEIGHT_W - 1;
    localparam int HOLD_CYCLES  = 600;
    localparam int QUIET_LIMIT  = 20000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic holding = 1'b0;
    event hold_go;
    int   mismatch_count = 0;
    int   quiet_cycles = 0;

    // generator state mirror
    logic [DEG_W-1:0]  degree_mirror [MAX_V];
    logic [VTX_W-1:0]  picked_list [MAX_S];
    int unsigned       picked_n = 0;
    int unsigned       cur_vertex = 0;
    int unsigned       edge_count = 0;
    int unsigned       open_wt = 0;
    bit                gen_done = 1'b1;
    logic [VCNT_W-1:0] cfg_vertices = 11'd1024;
    logic [SCNT_W-1:0] cfg_seeds = 4'd4;
    int unsigned       run_vertices = 1;
    int unsigned       run_seeds = 1;
    rsp_t              expected_edges [$];

    always #6 clk = ~clk;

    preferential_attachment_graph_gen uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic rsp_t make_rsp(int unsigned s, int unsigned d, bit v, bit l, bit dn);
        rsp_t r;
        r.src_vertex = s[VTX_W-1:0];
        r.dst_vertex = d[VTX_W-1:0];
        r.edge_valid = v;
        r.last       = l;
        r.done_res   = dn;
        return r;
    endfunction

    function automatic void bump_degree(int unsigned v);
        if (v < MAX_V && degree_mirror[v] < DEG_MAX)
            degree_mirror[v] = degree_mirror[v] + 1'b1;
    endfunction

    function automatic int unsigned full_weight();
        int unsigned w;
        w = 2 * edge_count;
        return (w > WEIGHT_CAP) ? WEIGHT_CAP : w;
    endfunction

    function automatic void predict_start();
        int unsigned nv;
        int unsigned ns;
        rsp_t        clique [$];
        nv = cfg_vertices;
        ns = cfg_seeds;
        if (nv == 0) nv = 1;
        if (nv > MAX_V) nv = MAX_V;
        if (ns == 0) ns = 1;
        if (ns > MAX_S) ns = MAX_S;
        if (ns > nv) ns = nv;
        run_vertices = nv;
        run_seeds = ns;
        for (int i = 0; i < MAX_V; i++)
            degree_mirror[i] = '0;
        edge_count = 0;
        for (int unsigned i = 0; i < ns; i++)
        begin
            for (int unsigned j = i + 1; j < ns; j++)
            begin
                bump_degree(i);
                bump_degree(j);
                if (edge_count < EDGE_MAX) edge_count++;
                clique.push_back(make_rsp(i, j, 1'b1, 1'b0, 1'b0));
            end
        end
        picked_n = 0;
        cur_vertex = ns;
        open_wt = full_weight();
        gen_done = (cur_vertex >= nv);
        if (clique.size() == 0)
            clique.push_back(make_rsp(0, 0, 1'b0, 1'b1, 1'b0));
        else
            clique[clique.size() - 1].last = 1'b1;
        foreach (clique[n])
        begin
            clique[n].done_res = gen_done;
            expected_edges.push_back(clique[n]);
        end
    endfunction

    function automatic void predict_draw(logic [DRAW_W-1:0] frac);
        longint unsigned prod;
        int              rem;
        bit              taken;
        int unsigned     src;
        if (gen_done || cur_vertex >= MAX_V || picked_n >= MAX_S)
        begin
            expected_edges.push_back(make_rsp(0, 0, 1'b0, 1'b1, 1'b1));
            return;
        end
        // scale the fraction by the open weight, rounding half up
        prod = 64'(frac) * 64'(open_wt) * 2 + 64'(FRAC_MAX);
        rem = int'(prod / (2 * 64'(FRAC_MAX)));
        for (int unsigned j = 0; j < cur_vertex; j++)
        begin
            taken = 1'b0;
            for (int unsigned k = 0; k < picked_n; k++)
                if (picked_list[k] == j) taken = 1'b1;
            if (!taken)
            begin
                rem -= int'(degree_mirror[j]);
                if (rem <= 0)
                begin
                    src = cur_vertex;
                    if (open_wt >= degree_mirror[j])
                        open_wt -= degree_mirror[j];
                    else
                        open_wt = 0;
                    picked_list[picked_n] = j[VTX_W-1:0];
                    picked_n++;
                    bump_degree(j);
                    bump_degree(src);
                    if (edge_count < EDGE_MAX) edge_count++;
                    if (picked_n >= run_seeds)
                    begin
                        picked_n = 0;
                        cur_vertex++;
                        open_wt = full_weight();
                        if (cur_vertex >= run_vertices) gen_done = 1'b1;
                    end
                    expected_edges.push_back(make_rsp(src, j, 1'b1, 1'b1, gen_done));
                    return;
                end
            end
        end
        expected_edges.push_back(make_rsp(0, 0, 1'b0, 1'b1, 1'b0));
    endfunction

    // receiver: random stall plus the long hold-off
    always @(posedge clk)
        rsp_stall <= holding || ($urandom_range(0, 99) < recv_stall_pct);

    initial
    begin
        forever
        begin
            @(hold_go);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
        end
    end

    // response check, sampled mid-cycle ahead of the accepting edge
    always @(negedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_edges.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t unexpected word src=%0d dst=%0d v=%0b l=%0b d=%0b",
                             $realtime, rsp.src_vertex, rsp.dst_vertex, rsp.edge_valid,
                             rsp.last, rsp.done_res);
            end
            else
            begin
                want = expected_edges.pop_front();
                if (rsp.src_vertex !== want.src_vertex || rsp.dst_vertex !== want.dst_vertex ||
                    rsp.edge_valid !== want.edge_valid || rsp.last !== want.last ||
                    rsp.done_res !== want.done_res)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t mismatch exp src=%0d dst=%0d v=%0b l=%0b d=%0b, got src=%0d dst=%0d v=%0b l=%0b d=%0b",
                                 $realtime, want.src_vertex, want.dst_vertex, want.edge_valid,
                                 want.last, want.done_res, rsp.src_vertex, rsp.dst_vertex,
                                 rsp.edge_valid, rsp.last, rsp.done_res);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_word(input logic mode, input logic [DRAW_W-1:0] frac);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req.mode  <= mode;
        req.draw  <= frac;
        do
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end
        while (!taken);
        if (mode == MODE_START)
            predict_start();
        else
            predict_draw(frac);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        if (idx == REG_VERTEX_COUNT)
            cfg_vertices = val[VCNT_W-1:0];
        else if (idx == REG_SEED_COUNT)
            cfg_seeds = val[SCNT_W-1:0];
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] verts, input logic [CFG_DATA_W-1:0] seeds);
        write_reg(REG_VERTEX_COUNT, verts);
        write_reg(REG_SEED_COUNT, seeds);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_edges.size() != 0);
    endtask

    function automatic logic [DRAW_W-1:0] pick_fraction();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return DRAW_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic test_draw_before_start();
        send_word(MODE_DRAW, '0);
        send_word(MODE_DRAW, '1);
    endtask

    task automatic test_default_registers();
        send_word(MODE_START, '0);
        send_word(MODE_DRAW, 16'h8000);
        send_word(MODE_DRAW, '1);
        send_word(MODE_DRAW, 16'h5555);
    endtask

    task automatic test_register_limits();
        wait_drained();
        for (int i = REG_SEED_COUNT + 1; i < 2**CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), '1);
        configure(11'd0, 11'd0);
        send_word(MODE_START, '1);
        send_word(MODE_DRAW, 16'h1234);
        wait_drained();
        configure(11'h7FF, 11'h7FF);
        send_word(MODE_START, '0);
        send_word(MODE_DRAW, 16'hAAAA);
        wait_drained();
        configure(11'd2, 11'd8);
        send_word(MODE_START, '0);
        send_word(MODE_DRAW, '0);
    endtask

    task automatic test_empty_clique();
        wait_drained();
        configure(11'd3, 11'd1);
        send_word(MODE_START, '0);
        send_word(MODE_DRAW, '0);
        send_word(MODE_DRAW, '1);
        send_word(MODE_DRAW, 16'h7FFF);
    endtask

    task automatic test_draw_extremes();
        wait_drained();
        configure(11'd6, 11'd2);
        send_word(MODE_START, '0);
        for (int i = 0; i < 9; i++)
            send_word(MODE_DRAW, (i % 2 == 0) ? '0 : '1);
    endtask

    task automatic test_backpressure();
        wait_drained();
        configure(11'd24, 11'd3);
        send_word(MODE_START, '0);
        -> hold_go;
        for (int i = 0; i < 8; i++)
            send_word(MODE_DRAW, pick_fraction());
        wait_drained();
        for (int i = 0; i < 4; i++)
            send_word(MODE_DRAW, pick_fraction());
    endtask

    task automatic test_random_runs(input int idle_pct, input int stall_pct, input int budget);
        logic [CFG_DATA_W-1:0] verts;
        logic [SCNT_W-1:0]     seeds;
        int                    left;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (budget > 0)
        begin
            wait_drained();
            case ($urandom_range(0, 9))
                0:
                begin
                    verts = 11'd1024;
                    seeds = SCNT_W'($urandom_range(1, MAX_S));
                end
                1:
                begin
                    verts = CFG_DATA_W'($urandom_range(0, 2047));
                    seeds = SCNT_W'($urandom_range(0, 15));
                end
                2:
                begin
                    verts = CFG_DATA_W'($urandom_range(2, 12));
                    seeds = $urandom_range(0, 1) ? 4'd0 : 4'd15;
                end
                default:
                begin
                    verts = CFG_DATA_W'($urandom_range(2, 14));
                    seeds = SCNT_W'($urandom_range(1, 4));
                end
            endcase
            configure(verts, (CFG_DATA_W'($urandom) & 11'h7F0) | CFG_DATA_W'(seeds));
            send_word(MODE_START, DRAW_W'($urandom));
            budget--;
            left = (run_vertices - run_seeds) * run_seeds + $urandom_range(0, 2);
            while (left > 0 && budget > 0)
            begin
                if ($urandom_range(0, 29) == 0)
                    send_word(MODE_START, DRAW_W'($urandom));
                else
                    send_word(MODE_DRAW, pick_fraction());
                left--;
                budget--;
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < MAX_V; i++)
            degree_mirror[i] = '0;
        for (int i = 0; i < MAX_S; i++)
            picked_list[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_draw_before_start();
        test_default_registers();
        test_register_limits();
        test_empty_clique();
        test_draw_extremes();
        test_backpressure();
        test_random_runs(0, 0, 25);
        test_random_runs(51, 0, 25);
        test_random_runs(0, 51, 25);
        test_random_runs(32, 32, 25);

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && expected_edges.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

/* preferential_attachment_graph_gen.f */
+incdir+rtl
rtl/pagg_pkg.sv
rtl/pagg_ram.sv
rtl/pagg_scale.sv
rtl/preferential_attachment_graph_gen.sv
bench/tb_top.sv
